@@ rtl/msgenc_pkg.sv @@
// shared types and constants for the msgpack scalar and header encoder
package msgenc_pkg;

    // request type codes
    localparam logic [2:0] REQ_UINT    = 3'd0;
    localparam logic [2:0] REQ_SINT    = 3'd1;
    localparam logic [2:0] REQ_BIN     = 3'd2;
    localparam logic [2:0] REQ_ARRAY   = 3'd3;
    localparam logic [2:0] REQ_PAYLOAD = 3'd4;

    // lead bytes
    localparam logic [7:0] LEAD_UINT8   = 8'hcc;
    localparam logic [7:0] LEAD_UINT16  = 8'hcd;
    localparam logic [7:0] LEAD_UINT32  = 8'hce;
    localparam logic [7:0] LEAD_UINT64  = 8'hcf;
    localparam logic [7:0] LEAD_INT8    = 8'hd0;
    localparam logic [7:0] LEAD_INT16   = 8'hd1;
    localparam logic [7:0] LEAD_INT32   = 8'hd2;
    localparam logic [7:0] LEAD_INT64   = 8'hd3;
    localparam logic [7:0] LEAD_BIN8    = 8'hc4;
    localparam logic [7:0] LEAD_BIN16   = 8'hc5;
    localparam logic [7:0] LEAD_BIN32   = 8'hc6;
    localparam logic [7:0] LEAD_FIXARR  = 8'h90;
    localparam logic [7:0] LEAD_ARRAY16 = 8'hdc;
    localparam logic [7:0] LEAD_ARRAY32 = 8'hdd;

    // bytes of one encoded request, left aligned: lead byte then body
    localparam int unsigned MAX_BYTES = 9;
    localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int unsigned SEQ_W     = 8 * MAX_BYTES;

    typedef struct packed {
        logic             keep;   // request produces output
        logic [CNT_W-1:0] total;  // bytes to send, 1 to 9
        logic [SEQ_W-1:0] seq;    // byte sequence, first byte in msbs
    } hdr_t;

endpackage

@@ rtl/msgenc_classify.sv @@
// picks the smallest encoding for a request and lays out its byte sequence
module msgenc_classify (
    input  logic [2:0]         req_type,
    input  logic [63:0]        value,
    output msgenc_pkg::hdr_t   hdr
);
    import msgenc_pkg::*;

    logic [63:0] mag;
    logic        v_u7, v_u8, v_u16, v_u32;
    logic        m_u5, m_u7, m_u15, m_u31;
    logic [7:0]  lead;
    logic [3:0]  nbytes;
    logic        keep;
    logic [63:0] body;

    // range tests on the raw value and on the signed magnitude
    always_comb
    begin
        mag   = value[63] ? ~value : value;
        v_u7  = (value[63:7]  == '0);
        v_u8  = (value[63:8]  == '0);
        v_u16 = (value[63:16] == '0);
        v_u32 = (value[63:32] == '0);
        m_u5  = (mag[63:5]    == '0);
        m_u7  = (mag[63:7]    == '0);
        m_u15 = (mag[63:15]   == '0);
        m_u31 = (mag[63:31]   == '0);
    end

    // lead byte and body length per request type
    always_comb
    begin
        lead   = value[7:0];
        nbytes = 4'd0;
        keep   = 1'b1;
        unique case (req_type)
            REQ_UINT:
            begin
                if (v_u7) begin
                    lead = value[7:0];
                end else if (v_u8) begin
                    lead = LEAD_UINT8;  nbytes = 4'd1;
                end else if (v_u16) begin
                    lead = LEAD_UINT16; nbytes = 4'd2;
                end else if (v_u32) begin
                    lead = LEAD_UINT32; nbytes = 4'd4;
                end else begin
                    lead = LEAD_UINT64; nbytes = 4'd8;
                end
            end
            REQ_SINT:
            begin
                if (value[63] && m_u5) begin
                    lead = value[7:0];
                end else if (!value[63] && v_u7) begin
                    lead = value[7:0];
                end else if (m_u7) begin
                    lead = LEAD_INT8;  nbytes = 4'd1;
                end else if (m_u15) begin
                    lead = LEAD_INT16; nbytes = 4'd2;
                end else if (m_u31) begin
                    lead = LEAD_INT32; nbytes = 4'd4;
                end else begin
                    lead = LEAD_INT64; nbytes = 4'd8;
                end
            end
            REQ_BIN:
            begin
                if (v_u8) begin
                    lead = LEAD_BIN8;  nbytes = 4'd1;
                end else if (v_u16) begin
                    lead = LEAD_BIN16; nbytes = 4'd2;
                end else if (v_u32) begin
                    lead = LEAD_BIN32; nbytes = 4'd4;
                end else begin
                    keep = 1'b0;
                end
            end
            REQ_ARRAY:
            begin
                if (value[63:4] == '0) begin
                    lead = LEAD_FIXARR | {4'd0, value[3:0]};
                end else if (v_u16) begin
                    lead = LEAD_ARRAY16; nbytes = 4'd2;
                end else if (v_u32) begin
                    lead = LEAD_ARRAY32; nbytes = 4'd4;
                end else begin
                    keep = 1'b0;
                end
            end
            REQ_PAYLOAD:
            begin
                lead = value[7:0];
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // left align the low nbytes of the value behind the lead byte
    always_comb
    begin
        case (nbytes)
            4'd1:    body = {value[7:0],  56'd0};
            4'd2:    body = {value[15:0], 48'd0};
            4'd4:    body = {value[31:0], 32'd0};
            4'd8:    body = value;
            default: body = 64'd0;
        endcase
        hdr.keep  = keep;
        hdr.total = CNT_W'(nbytes) + CNT_W'(1);
        hdr.seq   = {lead, body};
    end

endmodule

@@ rtl/msgenc_serializer.sv @@
// holds one encoded request and sends it out a byte per cycle, while out_stall allows, through an output register
module msgenc_serializer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  msgenc_pkg::hdr_t hdr,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             last
);
    import msgenc_pkg::*;

    logic             item_valid_reg, item_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             last_reg, last_next;

    logic out_free;
    logic pop;
    logic item_done;
    logic load;

    // handshake: a new request may enter as the held one hands over its last byte
    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        pop       = item_valid_reg && out_free;
        item_done = pop && (cnt_reg == CNT_W'(1));
        in_stall  = item_valid_reg && !item_done;
        load      = in_valid && !in_stall && hdr.keep;
    end

    // next state of item and output registers
    always_comb
    begin
        item_valid_next = item_valid_reg;
        cnt_next        = cnt_reg;
        seq_next        = seq_reg;
        if (pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            seq_next = {seq_reg[SEQ_W-9:0], 8'd0};
        end
        if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        if (load)
        begin
            item_valid_next = 1'b1;
            cnt_next        = hdr.total;
            seq_next        = hdr.seq;
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = seq_reg[SEQ_W-1 -: 8];
            last_next      = (cnt_reg == CNT_W'(1));
        end else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        seq_reg      <= seq_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

@@ rtl/msgpack_scalar_header_encoder_unit.sv @@
// top level of the msgpack scalar and header encoder
//
// Input channel: in_valid / in_stall with req_type and value. Each request is
// an unsigned int, signed int, binary header, array header or payload byte.
// Output channel: out_valid / out_stall with out_byte and last, one byte of
// the encoding per transfer, lead byte first, last set on the final byte.
// Integers always take the smallest encoding. Unknown request types and
// binary lengths or array counts above 32 bits are accepted and dropped.
//
// The first byte of an accepted request passes through the holding register
// and then the output register before out_valid rises for it.
// Throughput: one output byte per cycle while out_stall is low; a request of
// n bytes (1 to 9) holds the input until it hands over its last byte, and
// the next request is taken in that same cycle, so requests run back to back.
// The byte rate is set by the single byte-wide output register.
// Reset clears the held request and the output register; no byte is lost or
// repeated when out_stall is high, the output byte simply holds and the
// input stalls once the held request has no byte left to move forward.
module msgpack_scalar_header_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last
);
    import msgenc_pkg::*;

    hdr_t hdr;

    // encoding choice for the request on the input ports
    msgenc_classify u_classify (
        .req_type (req_type),
        .value    (value),
        .hdr      (hdr)
    );

    // byte sequencing and output register
    msgenc_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hdr       (hdr),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

@@ rtl/msgenc_checker.sv @@
// port level checks for the msgpack encoder, bound to the top level
module msgenc_props (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        last
);
    import msgenc_pkg::*;

    // a stalled output byte holds
    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output byte changed while stalled");

    // bytes of one request follow without gaps
    ast_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside an encoded request");

    // a dropped request of an unknown type never blocks the input
    ast_drop_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type > REQ_PAYLOAD)
        |=> !in_stall)
        else $error("unknown request held the input");

    // a payload byte is one byte long, so the input frees when the output moves
    ast_payload_one: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type == REQ_PAYLOAD) ##1 !out_stall |-> !in_stall)
        else $error("payload byte request took more than one byte");

endmodule

bind msgpack_scalar_header_encoder_unit msgenc_props u_msgenc_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

@@ verif/msgenc_checker.sv @@
// checker for the msgpack encoder: predicts encoded bytes per request and compares outputs
`timescale 1ns / 100ps

module msgenc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [63:0] value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          bytes_checked
);
    import msgenc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } enc_byte_t;

    // bytes still owed by the block, oldest first
    enc_byte_t encoded_bytes_q[$];

    // append the encoding of one request to the expected byte stream
    task automatic msgpack_encode(input logic [2:0] rt, input logic [63:0] v);
        logic [7:0]  lead;
        logic [63:0] mag;
        logic [63:0] body;
        logic        keep;
        int          nbody;
        enc_byte_t   eb;
        keep  = 1'b1;
        nbody = 0;
        lead  = v[7:0];
        mag   = v[63] ? ~v : v;
        case (rt)
            REQ_UINT:
            begin
                if (v <= 64'h7f) lead = v[7:0];
                else if (v <= 64'hff) begin lead = LEAD_UINT8; nbody = 1; end
                else if (v <= 64'hffff) begin lead = LEAD_UINT16; nbody = 2; end
                else if (v <= 64'hffff_ffff) begin lead = LEAD_UINT32; nbody = 4; end
                else begin lead = LEAD_UINT64; nbody = 8; end
            end
            REQ_SINT:
            begin
                // negative fixint, positive fixint, then smallest signed width
                if (v[63] && mag <= 64'd31) lead = v[7:0];
                else if (!v[63] && v <= 64'h7f) lead = v[7:0];
                else if (mag <= 64'h7f) begin lead = LEAD_INT8; nbody = 1; end
                else if (mag <= 64'h7fff) begin lead = LEAD_INT16; nbody = 2; end
                else if (mag <= 64'h7fff_ffff) begin lead = LEAD_INT32; nbody = 4; end
                else begin lead = LEAD_INT64; nbody = 8; end
            end
            REQ_BIN:
            begin
                if (v <= 64'hff) begin lead = LEAD_BIN8; nbody = 1; end
                else if (v <= 64'hffff) begin lead = LEAD_BIN16; nbody = 2; end
                else if (v <= 64'hffff_ffff) begin lead = LEAD_BIN32; nbody = 4; end
                else keep = 1'b0;
            end
            REQ_ARRAY:
            begin
                if (v <= 64'd15) lead = LEAD_FIXARR | v[7:0];
                else if (v <= 64'hffff) begin lead = LEAD_ARRAY16; nbody = 2; end
                else if (v <= 64'hffff_ffff) begin lead = LEAD_ARRAY32; nbody = 4; end
                else keep = 1'b0;
            end
            REQ_PAYLOAD: lead = v[7:0];
            default: keep = 1'b0;
        endcase
        if (keep)
        begin
            eb.data = lead;
            eb.fin  = (nbody == 0);
            encoded_bytes_q.push_back(eb);
            // body bytes, most significant first
            for (int k = 0; k < nbody; k++)
            begin
                body    = v >> (8 * (nbody - 1 - k));
                eb.data = body[7:0];
                eb.fin  = (k == nbody - 1);
                encoded_bytes_q.push_back(eb);
            end
        end
    endtask

    // compare accepted bytes, then predict from accepted requests
    always @(posedge clk or negedge rst_n)
    begin : watch
        enc_byte_t want;
        int        errs;
        if (!rst_n)
        begin
            encoded_bytes_q.delete();
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (out_valid && !out_stall)
            begin
                if (encoded_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected byte, expected none, actual byte %h last %b",
                             $time, out_byte, last);
                    errs++;
                end
                else
                begin
                    want = encoded_bytes_q.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $display("%0t: out_byte mismatch, expected %h actual %h",
                                 $time, want.data, out_byte);
                        errs++;
                    end
                    if (last !== want.fin)
                    begin
                        $display("%0t: last mismatch, expected %b actual %b",
                                 $time, want.fin, last);
                        errs++;
                    end
                    bytes_checked <= bytes_checked + 1;
                end
            end
            if (in_valid && !in_stall)
                msgpack_encode(req_type, value);
            fail_count <= fail_count + errs;
            pending    <= encoded_bytes_q.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// testbench top for the msgpack encoder: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import msgenc_pkg::*;

    // reserved request codes, accepted and dropped by the block
    localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;

    localparam int NUM_RANDOM   = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int HOLD_AT      = 60;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [2:0]  req_type  = REQ_UINT;
    logic [63:0] value     = 64'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        last;

    int   fail_count;
    int   pending;
    int   bytes_checked;
    int   reqs_sent    = 0;
    int   reqs_dropped = 0;
    int   idle_cycles  = 0;
    bit   gaps_on      = 1'b1;
    bit   hold_done    = 1'b0;

    msgpack_scalar_header_encoder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    msgenc_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d bytes outstanding",
                     $time, idle_cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one request, called at a falling edge, returns at a falling edge
    task automatic send_req(input logic [2:0] rt, input logic [63:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        value    <= v;
        do @(posedge clk); while (in_stall);
        reqs_sent++;
        if (rt > REQ_PAYLOAD || ((rt == REQ_BIN || rt == REQ_ARRAY) && v > 64'hffff_ffff))
            reqs_dropped++;
        @(negedge clk);
    endtask

    // random bits in the low nbits positions
    function automatic logic [63:0] rand_bits(input int nbits);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (nbits < 64)
            r = r & ((64'd1 << nbits) - 64'd1);
        return r;
    endfunction

    // value for a request, spread over every encoding width and its edges
    function automatic logic [63:0] rand_value(input logic [2:0] rt);
        int          nb;
        logic [63:0] v;
        case (rt)
            REQ_BIN, REQ_ARRAY:
                nb = ($urandom_range(0, 19) == 0) ? $urandom_range(33, 64)
                                                  : $urandom_range(1, 32);
            REQ_PAYLOAD: nb = 64;
            default: nb = $urandom_range(1, 64);
        endcase
        v = rand_bits(nb);
        // width boundaries: all ones, or one past
        case ($urandom_range(0, 7))
            0: v = rand_bits(nb) | ~64'd0 & ((nb < 64) ? ((64'd1 << nb) - 64'd1) : ~64'd0);
            1: v = (nb < 64) ? (64'd1 << nb) : v;
            default: ;
        endcase
        if (rt == REQ_SINT && $urandom_range(0, 1))
            v = ~v;
        return v;
    endfunction

    // receiver: random stall per byte plus one long hold-off
    initial
    begin : receiver
        int gap;
        int taken;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!hold_done && taken == HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                gap = gaps_on ? $urandom_range(0, 9) : 0;
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [2:0]  rt;
        logic [63:0] v;
        int          counted;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: unsigned widths and bounds
        send_req(REQ_UINT, 64'd0);
        send_req(REQ_UINT, 64'd127);
        send_req(REQ_UINT, 64'd128);
        send_req(REQ_UINT, 64'd256);
        send_req(REQ_UINT, 64'h1_0000_0000);
        send_req(REQ_UINT, ~64'd0);
        // signed: fixint edges and each signed width
        send_req(REQ_SINT, -64'sd32);
        send_req(REQ_SINT, -64'sd33);
        send_req(REQ_SINT, 64'd128);
        send_req(REQ_SINT, -64'sd129);
        send_req(REQ_SINT, -64'sd32769);
        send_req(REQ_SINT, 64'h7fff_ffff);
        send_req(REQ_SINT, -64'sd2147483649);
        send_req(REQ_SINT, 64'h8000_0000_0000_0000);
        // binary and array headers, including oversized ones that are dropped
        send_req(REQ_BIN, 64'd255);
        send_req(REQ_BIN, 64'd256);
        send_req(REQ_BIN, 64'hffff_ffff);
        send_req(REQ_BIN, 64'h1_0000_0000);
        send_req(REQ_ARRAY, 64'd15);
        send_req(REQ_ARRAY, 64'd16);
        send_req(REQ_ARRAY, 64'h1_0000);
        send_req(REQ_ARRAY, ~64'd0);
        // payload byte with high bits set, and reserved codes
        send_req(REQ_PAYLOAD, 64'hffff_ffff_ffff_ff5a);
        send_req(REQ_RESERVED_FIRST, ~64'd0);
        send_req(REQ_RESERVED_LAST, 64'd1);

        // random requests, phases with and without gaps
        counted = 0;
        while (counted < NUM_RANDOM)
        begin
            if (counted % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 20))
                0: rt = REQ_RESERVED_FIRST + 3'($urandom_range(0, 2));
                1, 2, 3, 4, 5: rt = REQ_UINT;
                6, 7, 8, 9, 10: rt = REQ_SINT;
                11, 12, 13: rt = REQ_BIN;
                14, 15, 16: rt = REQ_ARRAY;
                default: rt = REQ_PAYLOAD;
            endcase
            v = rand_value(rt);
            send_req(rt, v);
            if (!(rt > REQ_PAYLOAD || ((rt == REQ_BIN || rt == REQ_ARRAY) && v > 64'hffff_ffff)))
                counted++;
        end
        in_valid <= 1'b0;

        // drain
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d requests over all five types plus reserved codes, %0d dropped",
                 reqs_sent, reqs_dropped);
        $display("summary: %0d encoded bytes compared, long output hold-off applied", bytes_checked);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
